[rtl/rlec_pkg.sv]
// Shared types and constants for the run-length encoder with ASCII run counts.
package rlec_pkg;

   localparam int unsigned LEN_W    = 11;
   localparam int unsigned QDEPTH   = 4;
   localparam int unsigned QPTR_W   = 2;
   localparam int unsigned QCNT_W   = 3;

   localparam logic [7:0] ASCII_ZERO       = 8'd48;
   localparam logic [7:0] RUN_CODE_CAP     = 8'd254;
   localparam logic [7:0] MAX_RUN_CODE_RST = 8'd57;

   typedef struct packed {
      logic [7:0]       symbol;
      logic [7:0]       count_code;
      logic             final_pair;
      logic [LEN_W-1:0] encoded_length;
      logic             worth_keeping;
   } pair_type;

   typedef struct packed {
      logic             room;
      logic             any;
      logic [QCNT_W-1:0] level;
   } queue_status_type;

endpackage

[rtl/rlec_queue.sv]
// Result queue: takes up to two pairs per cycle, hands out one per transfer.
module rlec_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   push_num,
   input  rlec_pkg::pair_type           push_first,
   input  rlec_pkg::pair_type           push_second,
   input  logic                         pop,
   output rlec_pkg::pair_type           head,
   output rlec_pkg::queue_status_type   status
);

   rlec_pkg::pair_type                  mem_ff [rlec_pkg::QDEPTH];
   logic [rlec_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [rlec_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [rlec_pkg::QCNT_W-1:0]         level_ff, level_in;
   logic [rlec_pkg::QPTR_W-1:0]         wr_next;

   assign wr_next = wr_ptr_ff + rlec_pkg::QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rlec_pkg::QPTR_W'(push_num);
      rd_ptr_in = rd_ptr_ff + rlec_pkg::QPTR_W'(pop);
      level_in  = level_ff + rlec_pkg::QCNT_W'(push_num) - rlec_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push_num == 2'd2) begin
         mem_ff[wr_next] <= push_second;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.any   = (level_ff != '0);
   assign status.room  = (level_ff <= rlec_pkg::QCNT_W'(rlec_pkg::QDEPTH - 2));
   assign status.level = level_ff;

endmodule

[rtl/run_length_encoder_ascii_count.sv]
// Top level: run-length encoder emitting (symbol, ASCII count) pairs per block.
//
//  channel  dir  group                 payload
//  req      in   tvalid/tready/tlast   tdata = data_byte; tlast = last_byte
//  rsp      out  tvalid/tready/tlast   tdata = symbol, count_code, encoded_length;
//                                      tlast = final_pair; tuser = worth_keeping
//  csr      in   wr_en/wr_data         max_run_code
//
// One byte accepted per cycle while the queue has room; each byte yields 0, 1 or 2 pairs into a 4-entry queue.
// Pairs are written into the registered queue and leave it one pair per rsp transfer.
// A byte is taken while the queue holds at most two pairs, leaving room for the closed
// run plus final pair that a block's last byte can push.
// Synchronous reset clears the run state, counters and queue; max_run_code returns to 57.
module run_length_encoder_ascii_count #(
   parameter int unsigned MAX_BLOCK_LEN = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] symbol, [15:8] count_code, [26:16] encoded_length
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] worth_keeping
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int unsigned IC_W    = $clog2(MAX_BLOCK_LEN + 1);
   localparam int unsigned OLIM_I  = (2 * MAX_BLOCK_LEN > 2047) ? 2047 : 2 * MAX_BLOCK_LEN;
   localparam int unsigned LEN_W   = rlec_pkg::LEN_W;
   localparam int unsigned CMP_W   = (IC_W > LEN_W) ? IC_W : LEN_W;
   localparam logic [LEN_W:0]  OLIM   = (LEN_W + 1)'(OLIM_I);
   localparam logic [IC_W-1:0] IC_MAX = IC_W'(MAX_BLOCK_LEN);

   logic [7:0]        max_code_ff;
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        run_code_ff, run_code_in;
   logic              have_prev_ff, have_prev_in;
   logic [IC_W-1:0]   in_count_ff, in_count_in;
   logic [LEN_W-1:0]  out_count_ff, out_count_in;

   logic              accept;
   logic              close_run;
   logic [7:0]        new_code;
   logic [IC_W-1:0]   ic_step;
   logic [LEN_W:0]    sum_one;
   logic [LEN_W-1:0]  oc_one;
   logic [LEN_W:0]    sum_two;
   logic [LEN_W-1:0]  oc_two;
   logic [LEN_W-1:0]  oc_fin;
   logic [1:0]        push_num;

   rlec_pkg::pair_type         closed_pair, fin_pair, first_pair, head;
   rlec_pkg::queue_status_type qstat;

   assign req_tready = qstat.room;
   assign accept     = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_code_ff <= rlec_pkg::MAX_RUN_CODE_RST;
      end else if (csr_wr_en) begin
         max_code_ff <= csr_wr_data;
      end
   end

   always_comb begin
      close_run = have_prev_ff && ((req_tdata != prev_ff) || (run_code_ff == max_code_ff)
                                  || (run_code_ff >= rlec_pkg::RUN_CODE_CAP));
      new_code  = (close_run || !have_prev_ff) ? rlec_pkg::ASCII_ZERO
                                               : run_code_ff + 8'd1;
      ic_step   = (in_count_ff < IC_MAX) ? in_count_ff + IC_W'(1) : in_count_ff;

      sum_one   = {1'b0, out_count_ff} + (LEN_W + 1)'(2);
      oc_one    = (sum_one > OLIM) ? OLIM[LEN_W-1:0] : sum_one[LEN_W-1:0];
      sum_two   = {1'b0, oc_one} + (LEN_W + 1)'(2);
      oc_two    = (sum_two > OLIM) ? OLIM[LEN_W-1:0] : sum_two[LEN_W-1:0];
      oc_fin    = close_run ? oc_two : oc_one;

      closed_pair.symbol         = prev_ff;
      closed_pair.count_code     = run_code_ff + 8'd1;
      closed_pair.final_pair     = 1'b0;
      closed_pair.encoded_length = oc_one;
      closed_pair.worth_keeping  = 1'b0;

      fin_pair.symbol            = req_tdata;
      fin_pair.count_code        = new_code + 8'd1;
      fin_pair.final_pair        = 1'b1;
      fin_pair.encoded_length    = oc_fin;
      fin_pair.worth_keeping     = (CMP_W'(oc_fin) < CMP_W'(ic_step));

      first_pair = close_run ? closed_pair : fin_pair;
      push_num   = accept ? (2'(close_run) + 2'(req_tlast)) : 2'd0;

      prev_in      = prev_ff;
      run_code_in  = run_code_ff;
      have_prev_in = have_prev_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      if (accept) begin
         if (req_tlast) begin
            prev_in      = '0;
            run_code_in  = rlec_pkg::ASCII_ZERO;
            have_prev_in = 1'b0;
            in_count_in  = '0;
            out_count_in = '0;
         end else begin
            prev_in      = req_tdata;
            run_code_in  = new_code;
            have_prev_in = 1'b1;
            in_count_in  = ic_step;
            out_count_in = close_run ? oc_one : out_count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         run_code_ff  <= rlec_pkg::ASCII_ZERO;
         have_prev_ff <= 1'b0;
         in_count_ff  <= '0;
         out_count_ff <= '0;
      end else begin
         prev_ff      <= prev_in;
         run_code_ff  <= run_code_in;
         have_prev_ff <= have_prev_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
      end
   end

   rlec_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_num    (push_num),
      .push_first  (first_pair),
      .push_second (fin_pair),
      .pop         (rsp_tvalid & rsp_tready),
      .head        (head),
      .status      (qstat)
   );

   assign rsp_tvalid = qstat.any;
   assign rsp_tdata  = {5'd0, head.encoded_length, head.count_code, head.symbol};
   assign rsp_tlast  = head.final_pair;
   assign rsp_tuser  = head.worth_keeping;

   // block end restores the idle run state
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !have_prev_ff && (out_count_ff == '0))
      else $error("run state not cleared after last byte");

   // only the final pair may report a shrink
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tuser)
      else $error("worth_keeping set on non-final pair");

   // run code never passes the hard cap
   assert property (@(posedge clock) disable iff (reset)
      run_code_ff <= rlec_pkg::RUN_CODE_CAP)
      else $error("run code beyond cap");

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      qstat.level <= rlec_pkg::QCNT_W'(rlec_pkg::QDEPTH))
      else $error("result queue overflow");

endmodule

[tb/run_length_encoder_ascii_count_tb.sv]
// Self-checking testbench for the run-length encoder with ASCII run counts.
`timescale 1ns / 1ps

module run_length_encoder_ascii_count_tb;

   localparam int MAX_BLOCK_LEN = 512;
   localparam int OUT_CAP       = 2 * MAX_BLOCK_LEN;
   localparam int N_DIR         = 22;
   localparam rlec_pkg::pair_type NO_PAIR = '0;

   typedef struct packed {
      logic [7:0]         data;
      logic               last;
      logic               typed;
      rlec_pkg::pair_type want;
   } dir_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   // encoder state mirror
   logic [7:0] max_code  = rlec_pkg::MAX_RUN_CODE_RST;
   logic [7:0] prev_byte = '0;
   logic [7:0] run_code  = rlec_pkg::ASCII_ZERO;
   logic       have_prev = 1'b0;
   int         blk_in_count  = 0;
   int         blk_out_count = 0;

   rlec_pkg::pair_type pending_pairs[$];
   int                 bad_count  = 0;
   bit                 tx_quiet   = 1'b0;
   bit                 rx_quiet   = 1'b0;
   int                 rx_wait    = 0;
   bit                 row_typed  = 1'b0;
   rlec_pkg::pair_type row_expect = '0;
   dir_row_type        dir_rows [N_DIR];

   run_length_encoder_ascii_count #(.MAX_BLOCK_LEN(MAX_BLOCK_LEN)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic emit_pair(input logic [7:0] sym, input logic [7:0] code, input logic fin,
                            input bit keep);
      rlec_pkg::pair_type p;
      blk_out_count = (blk_out_count + 2 > OUT_CAP) ? OUT_CAP : blk_out_count + 2;
      p.symbol         = sym;
      p.count_code     = code;
      p.final_pair     = fin;
      p.encoded_length = blk_out_count[rlec_pkg::LEN_W-1:0];
      p.worth_keeping  = fin && (blk_out_count < blk_in_count);
      if (keep)
         pending_pairs.push_back(p);
   endtask

   task automatic encode_byte(input logic [7:0] b, input logic last, input bit keep);
      if (blk_in_count < MAX_BLOCK_LEN)
         blk_in_count++;
      if (!have_prev) begin
         have_prev = 1'b1;
         run_code  = rlec_pkg::ASCII_ZERO;
      end else if (b != prev_byte || run_code == max_code
                   || run_code >= rlec_pkg::RUN_CODE_CAP) begin
         emit_pair(prev_byte, run_code + 8'd1, 1'b0, keep);
         run_code = rlec_pkg::ASCII_ZERO;
      end else begin
         run_code = run_code + 8'd1;
      end
      prev_byte = b;
      if (last) begin
         emit_pair(b, run_code + 8'd1, 1'b1, keep);
         prev_byte     = '0;
         run_code      = rlec_pkg::ASCII_ZERO;
         have_prev     = 1'b0;
         blk_in_count  = 0;
         blk_out_count = 0;
      end
   endtask

   function automatic void note_mismatch(input rlec_pkg::pair_type want,
                                         input rlec_pkg::pair_type got,
                                         input bit orphan);
      if (bad_count < 10) begin
         if (orphan)
            $display("ERROR %0t: unexpected pair sym=%h code=%h fin=%b len=%0d keep=%b",
                     $realtime, got.symbol, got.count_code, got.final_pair,
                     got.encoded_length, got.worth_keeping);
         else
            $display("ERROR %0t: exp sym=%h code=%h fin=%b len=%0d keep=%b / got sym=%h code=%h fin=%b len=%0d keep=%b",
                     $realtime, want.symbol, want.count_code, want.final_pair,
                     want.encoded_length, want.worth_keeping, got.symbol, got.count_code,
                     got.final_pair, got.encoded_length, got.worth_keeping);
      end
      bad_count++;
   endfunction

   // transfer monitor: predicts on accepted bytes, checks accepted pairs
   always @(posedge clock) begin
      rlec_pkg::pair_type got;
      rlec_pkg::pair_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (row_typed) begin
               encode_byte(req_tdata, req_tlast, 1'b0);
               pending_pairs.push_back(row_expect);
            end else begin
               encode_byte(req_tdata, req_tlast, 1'b1);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.symbol         = rsp_tdata[7:0];
            got.count_code     = rsp_tdata[15:8];
            got.final_pair     = rsp_tlast;
            got.encoded_length = rsp_tdata[26:16];
            got.worth_keeping  = rsp_tuser;
            if (pending_pairs.size() == 0) begin
               note_mismatch(NO_PAIR, got, 1'b1);
            end else begin
               want = pending_pairs.pop_front();
               if (got.symbol != want.symbol || got.count_code != want.count_code ||
                   got.final_pair != want.final_pair ||
                   got.encoded_length != want.encoded_length ||
                   got.worth_keeping != want.worth_keeping)
                  note_mismatch(want, got, 1'b0);
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 6);
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= (rx_wait == 0);
      if (rx_wait > 0)
         rx_wait--;
   end

   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input rlec_pkg::pair_type want);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed   = typed;
      row_expect  = want;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      row_typed   = 1'b0;
      @(negedge clock);
      while (pending_pairs.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_max_code(input logic [7:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      max_code     = v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int longest_run(input logic [7:0] code);
      return (code >= rlec_pkg::ASCII_ZERO && code <= rlec_pkg::RUN_CODE_CAP)
             ? int'(code) - 47 : 207;
   endfunction

   task automatic random_blocks(input int n_items);
      int left;
      int run;
      int top;
      logic [7:0] sym;
      sym = 8'($urandom_range(0, 255));
      top = longest_run(max_code);
      while (n_items > 0) begin
         left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 240) : $urandom_range(1, 24);
         if (left > n_items)
            left = n_items;
         n_items -= left;
         while (left > 0) begin
            case ($urandom_range(0, 3))
               0: run = 1;
               1: run = $urandom_range(1, 5);
               2: run = $urandom_range((top > 1) ? top - 1 : 1, top + 2);
               default: run = $urandom_range(1, 2 * top);
            endcase
            case ($urandom_range(0, 5))
               0: sym = sym;
               1: sym = 8'h00;
               2: sym = 8'hFF;
               default: sym = 8'($urandom_range(0, 255));
            endcase
            while (run > 0 && left > 0) begin
               send_byte(sym, left == 1, 1'b0, NO_PAIR);
               run--;
               left--;
            end
         end
      end
   endtask

   task automatic run_phase(input logic [7:0] code, input int n_items);
      int n;
      int top;
      logic [7:0] sym;
      wait_idle();
      write_max_code(code);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      top = longest_run(code);
      if (top > 100) begin
         // one run past the cap inside a single block
         n   = top + 1 + $urandom_range(0, 1);
         sym = 8'($urandom_range(0, 255));
         while (n > 0) begin
            send_byte(sym, n == 1, 1'b0, NO_PAIR);
            n--;
         end
      end
      random_blocks(n_items);
   endtask

   initial begin
      int i;
      logic [7:0] sym;

      dir_rows[0] = '{8'h00, 1'b1, 1'b1,
                      '{8'h00, rlec_pkg::ASCII_ZERO + 8'd1, 1'b1, 11'd2, 1'b0}};
      dir_rows[1] = '{8'hFF, 1'b1, 1'b1,
                      '{8'hFF, rlec_pkg::ASCII_ZERO + 8'd1, 1'b1, 11'd2, 1'b0}};
      dir_rows[2] = '{8'h55, 1'b1, 1'b1,
                      '{8'h55, rlec_pkg::ASCII_ZERO + 8'd1, 1'b1, 11'd2, 1'b0}};
      dir_rows[3] = '{8'hAA, 1'b1, 1'b1,
                      '{8'hAA, rlec_pkg::ASCII_ZERO + 8'd1, 1'b1, 11'd2, 1'b0}};
      // run of twelve under the reset limit: closes after ten
      for (i = 4; i < 15; i++)
         dir_rows[i] = '{8'h5A, 1'b0, 1'b0, NO_PAIR};
      dir_rows[15] = '{8'h5A, 1'b1, 1'b0, NO_PAIR};
      // change on the last byte: closed run plus final pair
      dir_rows[16] = '{8'h01, 1'b0, 1'b0, NO_PAIR};
      dir_rows[17] = '{8'h02, 1'b1, 1'b0, NO_PAIR};
      // short block that shrinks
      dir_rows[18] = '{8'h80, 1'b0, 1'b0, NO_PAIR};
      dir_rows[19] = '{8'h80, 1'b0, 1'b0, NO_PAIR};
      dir_rows[20] = '{8'h80, 1'b0, 1'b0, NO_PAIR};
      dir_rows[21] = '{8'h80, 1'b1, 1'b0, NO_PAIR};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_quiet = ($urandom_range(0, 1) == 0);
      rx_quiet = ($urandom_range(0, 1) == 0);
      for (i = 0; i < N_DIR; i++)
         send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

      run_phase(8'd48, 30);
      run_phase(8'd254, 25);
      run_phase(8'd255, 20);
      run_phase(8'd0, 20);
      run_phase(8'd47, 25);
      run_phase(8'($urandom_range(49, 253)), 40);
      run_phase(rlec_pkg::MAX_RUN_CODE_RST, 40);

      // block past the length limit with a pair per byte: both counters saturate
      sym = 8'($urandom_range(0, 255));
      for (i = 0; i < 560; i++) begin
         send_byte(sym, i == 559, 1'b0, NO_PAIR);
         sym = sym ^ 8'($urandom_range(1, 255));
      end

      wait_idle();
      if (bad_count == 0 && pending_pairs.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
rtl/rlec_pkg.sv
rtl/rlec_queue.sv
rtl/run_length_encoder_ascii_count.sv
tb/run_length_encoder_ascii_count_tb.sv
